// ===== sv/att_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// att_pkg
// Types and constants shared by the animation tween table.
// ----------------------------------------------------------------------------
package att_pkg;
    localparam int SLOT_COUNT_DEF = 16;
    localparam int FRAME_BITS_DEF = 16;
    localparam int NODE_BITS_DEF  = 16;

    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    localparam logic [2:0] PROP_COLOUR = 3'd5;
    localparam logic [7:0] BYTE_MASK   = 8'hFF;
    localparam int         TOP_SHIFT   = 24;
    localparam int         QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] node_id;
        logic [2:0]  property_req;
        logic [31:0] color_dest;
        logic [31:0] start_value;
        logic [31:0] end_value;
        logic [15:0] frames;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] out_node;
        logic [2:0]  out_property;
        logic [31:0] out_color_dest;
        logic [31:0] value;
        logic        finished;
        logic        running;
        logic        last;
    } out_item_t;
endpackage

// ===== sv/att_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// att_in_if
// Valid/ready channel carrying command items.
// ----------------------------------------------------------------------------
interface att_in_if;
    import att_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/att_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// att_out_if
// Valid/ready channel carrying result items.
// ----------------------------------------------------------------------------
interface att_out_if;
    import att_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/animation_tween_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// animation_tween_table
// Table of linear tween animations stepped by frame ticks.
// ----------------------------------------------------------------------------
// in_ch carries command items (start, cancel, tick); out_ch carries results.
// Start and cancel produce no results and are handled by the back end
// in its idle state after passing a two-entry queue. A tick scans every
// slot, stepping over idle slots at one per cycle; an active slot with a
// plain value takes a scan, a multiply, a bit-serial divide of
// 33+FRAME_BITS bits and an emit; a colour slot repeats the multiply and
// divide for each of its four byte lanes; a slot on its last frame skips
// the divide. The divider dominates the length of a tick. Results leave
// through an output register; if the receiver stalls, the scan waits at
// the next active slot and the queue fills, then in_ch.ready drops. Reset
// clears the active flags, the queue and the sequencer; slot contents are
// written on start.
// ----------------------------------------------------------------------------
module animation_tween_table
    import att_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int FRAME_BITS = FRAME_BITS_DEF,
    parameter int NODE_BITS  = NODE_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    att_in_if.sink    in_ch,
    att_out_if.source out_ch
);
    att_in_if q_ch ();

    att_front #(
        .NODE_BITS (NODE_BITS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .q_ch  (q_ch.source)
    );

    att_back #(
        .SLOT_COUNT (SLOT_COUNT),
        .FRAME_BITS (FRAME_BITS),
        .NODE_BITS  (NODE_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_ch   (q_ch.sink),
        .out_ch (out_ch)
    );
endmodule

// ===== sv/att_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// att_front
// Accepts items, drops the ones that do nothing, and queues the rest.
// ----------------------------------------------------------------------------
module att_front
    import att_pkg::*;
#(
    parameter int NODE_BITS = NODE_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    att_in_if.sink   in_ch,
    att_in_if.source q_ch
);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NB = (NODE_BITS < 16) ? NODE_BITS : 16;

    in_item_t        mem [QUEUE_DEPTH];
    logic [PW-1:0]   wp_reg, rp_reg;
    logic [PW:0]     cnt_reg;
    logic            keep, push, pop;

    always_comb
    begin
        unique case (in_ch.data.cmd)
            CMD_START:  keep = (in_ch.data.node_id[NB-1:0] != '0) && (in_ch.data.frames != '0);
            CMD_CANCEL: keep = (in_ch.data.node_id[NB-1:0] != '0);
            CMD_TICK:   keep = 1'b1;
            default:    keep = 1'b0;
        endcase
    end

    assign in_ch.ready = (cnt_reg != (PW+1)'(QUEUE_DEPTH));
    assign push        = in_ch.valid && in_ch.ready && keep;
    assign q_ch.valid  = (cnt_reg != '0);
    assign q_ch.data   = mem[rp_reg];
    assign pop         = q_ch.valid && q_ch.ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= in_ch.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == PW'(QUEUE_DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == PW'(QUEUE_DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end
endmodule

// ===== sv/att_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// att_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module att_divider #(
    parameter int NUM_BITS = 48,
    parameter int DEN_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic                done,
    output logic [NUM_BITS-1:0] quot
);
    localparam int CW = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] q_reg;
    logic [DEN_BITS:0]   r_reg;
    logic [DEN_BITS-1:0] d_reg;
    logic [CW-1:0]       cnt_reg;
    logic                busy_reg, done_reg;
    logic [DEN_BITS:0]   shifted;
    logic                ge;

    assign shifted = {r_reg[DEN_BITS-1:0], q_reg[NUM_BITS-1]};
    assign ge      = shifted >= {1'b0, d_reg};
    assign done    = done_reg;
    assign quot    = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NUM_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            r_reg <= ge ? shifted - {1'b0, d_reg} : shifted;
            q_reg <= {q_reg[NUM_BITS-2:0], ge};
        end
    end
endmodule

// ===== sv/att_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// att_back
// Slot table and sequencer: start, cancel and the per-tick interpolation.
// ----------------------------------------------------------------------------
module att_back
    import att_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int FRAME_BITS = FRAME_BITS_DEF,
    parameter int NODE_BITS  = NODE_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    att_in_if.sink    q_ch,
    att_out_if.source out_ch
);
    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int NB = (NODE_BITS < 16) ? NODE_BITS : 16;
    localparam int PB = 33 + FRAME_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_MUL, S_DIV, S_EMIT, S_STATUS
    } state_t;

    logic [SLOT_COUNT-1:0] active_reg;
    logic [NB-1:0]         node_mem  [SLOT_COUNT];
    logic [2:0]            prop_mem  [SLOT_COUNT];
    logic [31:0]           dest_mem  [SLOT_COUNT];
    logic [31:0]           start_mem [SLOT_COUNT];
    logic [31:0]           end_mem   [SLOT_COUNT];
    logic [FRAME_BITS-1:0] dur_mem   [SLOT_COUNT];
    logic [FRAME_BITS-1:0] frame_mem [SLOT_COUNT];

    state_t                state_reg;
    logic [SW-1:0]         idx_reg;
    logic [1:0]            lane_reg;
    logic                  running_reg;
    logic                  colour_reg;
    logic [31:0]           a_reg, b_reg, acc_reg;
    logic [FRAME_BITS-1:0] t_reg, dur_reg;
    logic                  neg_reg;
    logic [PB-1:0]         prod_reg;
    logic                  div_start_reg;
    logic                  out_valid_reg;
    out_item_t             out_reg;

    logic                  div_done;
    logic [PB-1:0]         div_q;

    att_divider #(.NUM_BITS(PB), .DEN_BITS(FRAME_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (prod_reg),
        .den   (dur_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    // slot lookup for start items
    logic [NB-1:0]  q_node;
    logic [SW-1:0]  hit_idx, free_idx;
    logic           hit_any, free_any;
    assign q_node = q_ch.data.node_id[NB-1:0];

    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        hit_any  = 1'b0;
        free_any = 1'b0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (active_reg[i] && node_mem[i] == q_node && prop_mem[i] == q_ch.data.property_req)
            begin
                hit_idx = SW'(i);
                hit_any = 1'b1;
            end
            if (!active_reg[i])
            begin
                free_idx = SW'(i);
                free_any = 1'b1;
            end
        end
    end

    // operand for the current lane
    logic signed [32:0] sa, sb, diff;
    logic [FRAME_BITS-1:0] t_next;
    logic [31:0] lane_res;
    logic signed [33:0] res_wide;
    logic last_frame;

    always_comb
    begin
        if (colour_reg)
        begin
            sa = {25'd0, a_reg[8*lane_reg +: 8]};
            sb = {25'd0, b_reg[8*lane_reg +: 8]};
        end
        else
        begin
            sa = {a_reg[31], a_reg};
            sb = {b_reg[31], b_reg};
        end
        diff = sb - sa;
        res_wide = neg_reg ? ({sa[32], sa} - {1'b0, div_q[32:0]})
                           : ({sa[32], sa} + {1'b0, div_q[32:0]});
        lane_res = res_wide[31:0];
    end

    assign t_next     = frame_mem[idx_reg] + 1'b1;
    assign last_frame = (dur_reg == '0) || (t_reg >= dur_reg);

    assign q_ch.ready   = (state_reg == S_IDLE) &&
                          !(q_ch.data.cmd == CMD_TICK && out_valid_reg);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_ch.valid && q_ch.ready && q_ch.data.cmd == CMD_START
            && (hit_any || free_any))
        begin
            node_mem[hit_any ? hit_idx : free_idx]  <= q_node;
            prop_mem[hit_any ? hit_idx : free_idx]  <= q_ch.data.property_req;
            dest_mem[hit_any ? hit_idx : free_idx]  <= q_ch.data.color_dest;
            start_mem[hit_any ? hit_idx : free_idx] <= q_ch.data.start_value;
            end_mem[hit_any ? hit_idx : free_idx]   <= q_ch.data.end_value;
            dur_mem[hit_any ? hit_idx : free_idx]   <= FRAME_BITS'(q_ch.data.frames);
            frame_mem[hit_any ? hit_idx : free_idx] <= '0;
        end
        else if (state_reg == S_SCAN && active_reg[idx_reg] && !out_valid_reg)
        begin
            frame_mem[idx_reg] <= t_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= '0;
            idx_reg       <= '0;
            lane_reg      <= '0;
            running_reg   <= 1'b0;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (out_ch.valid && out_ch.ready && state_reg != S_STATUS)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_ch.valid && q_ch.ready)
                    begin
                        case (q_ch.data.cmd)
                            CMD_START:
                            begin
                                if (hit_any)
                                    active_reg[hit_idx] <= 1'b1;
                                else if (free_any)
                                    active_reg[free_idx] <= 1'b1;
                            end
                            CMD_CANCEL:
                            begin
                                for (int i = 0; i < SLOT_COUNT; i++)
                                    if (node_mem[i] == q_node)
                                        active_reg[i] <= 1'b0;
                            end
                            default:
                            begin
                                idx_reg     <= '0;
                                running_reg <= 1'b0;
                                state_reg   <= S_SCAN;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (!active_reg[idx_reg])
                    begin
                        if (idx_reg == SW'(SLOT_COUNT - 1))
                            state_reg <= S_STATUS;
                        else
                            idx_reg <= idx_reg + 1'b1;
                    end
                    else if (!out_valid_reg)
                    begin
                        a_reg      <= start_mem[idx_reg];
                        b_reg      <= end_mem[idx_reg];
                        t_reg      <= t_next;
                        dur_reg    <= dur_mem[idx_reg];
                        colour_reg <= (prop_mem[idx_reg] == PROP_COLOUR);
                        lane_reg   <= '0;
                        acc_reg    <= '0;
                        state_reg  <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    if (last_frame)
                    begin
                        acc_reg   <= b_reg;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        neg_reg   <= diff[32];
                        state_reg <= S_DIV;
                        prod_reg  <= PB'((diff[32] ? 33'(-diff) : 33'(diff)) * t_reg);
                        div_start_reg <= 1'b1;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        if (!colour_reg)
                        begin
                            acc_reg   <= lane_res;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            acc_reg[8*lane_reg +: 8] <= lane_res[7:0] & BYTE_MASK;
                            if (32'(lane_reg) * 8 == TOP_SHIFT)
                                state_reg <= S_EMIT;
                            else
                            begin
                                lane_reg  <= lane_reg + 1'b1;
                                state_reg <= S_MUL;
                            end
                        end
                    end
                end
                S_EMIT:
                begin
                    out_valid_reg          <= 1'b1;
                    out_reg.kind           <= 1'b0;
                    out_reg.out_node       <= 16'(node_mem[idx_reg]);
                    out_reg.out_property   <= prop_mem[idx_reg];
                    out_reg.out_color_dest <= dest_mem[idx_reg];
                    out_reg.value          <= acc_reg;
                    out_reg.finished       <= last_frame;
                    out_reg.running        <= 1'b0;
                    out_reg.last           <= 1'b0;
                    if (last_frame)
                        active_reg[idx_reg] <= 1'b0;
                    else
                        running_reg <= 1'b1;
                    if (idx_reg == SW'(SLOT_COUNT - 1))
                        state_reg <= S_STATUS;
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SCAN;
                    end
                end
                S_STATUS:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg       <= '{kind: 1'b1, out_node: 16'd0, out_property: 3'd0,
                                           out_color_dest: 32'd0, value: 32'd0,
                                           finished: 1'b0, running: running_reg,
                                           last: 1'b1};
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== tb/sv/animation_tween_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// animation_tween_table_tb
// Drives start, cancel and tick items into the tween table and compares
// every result item against a local slot-table predictor. A directed table
// covers the extremes and the ignored cases, then random animation traffic.
// ----------------------------------------------------------------------------
module animation_tween_table_tb;
    import att_pkg::*;

    localparam int NSLOT      = SLOT_COUNT_DEF;
    localparam int WDOG_LIMIT = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    att_in_if  in_ch ();
    att_out_if out_ch ();

    animation_tween_table DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always #6 clk = ~clk;

    // predictor copy of the slot table
    bit          tw_active [NSLOT];
    logic [15:0] tw_node   [NSLOT];
    logic [2:0]  tw_prop   [NSLOT];
    logic [31:0] tw_dest   [NSLOT];
    logic [31:0] tw_start  [NSLOT];
    logic [31:0] tw_end    [NSLOT];
    logic [15:0] tw_dur    [NSLOT];
    logic [15:0] tw_frame  [NSLOT];

    out_item_t pending_results [$];
    int        mismatches = 0;
    int        idle_cycles = 0;
    bit        quiet = 1'b0;      // no random idling
    bit        hold_rx = 1'b0;    // long receiver stall
    bit        timed_out = 1'b0;

    function automatic logic [31:0] lerp_word(logic [31:0] a, logic [31:0] b,
                                              logic [15:0] t, logic [15:0] dur);
        longint sa, sb, diff, q;
        sa = longint'($signed(a));
        sb = longint'($signed(b));
        if (dur == 0 || t >= dur)
            return b;
        diff = sb - sa;
        q = ((diff < 0 ? -diff : diff) * longint'(t)) / longint'(dur);
        return (diff < 0) ? 32'(sa - q) : 32'(sa + q);
    endfunction

    function automatic logic [31:0] lerp_argb(logic [31:0] a, logic [31:0] b,
                                              logic [15:0] t, logic [15:0] dur);
        logic [31:0] r;
        r = '0;
        if (dur == 0 || t >= dur)
            return b;
        for (int sh = 0; sh <= TOP_SHIFT; sh += 8)
            r[sh +: 8] = 8'(lerp_word({24'd0, a[sh +: 8]}, {24'd0, b[sh +: 8]}, t, dur))
                         & BYTE_MASK;
        return r;
    endfunction

    task automatic predict_tween(in_item_t it);
        int slot;
        bit run;
        out_item_t r;
        slot = -1;
        run = 0;
        case (it.cmd)
            CMD_START:
            begin
                if (it.node_id == 0 || it.frames == 0)
                    return;
                for (int i = 0; i < NSLOT; i++)
                    if (slot < 0 && tw_active[i] && tw_node[i] == it.node_id
                        && tw_prop[i] == it.property_req)
                        slot = i;
                for (int i = 0; i < NSLOT; i++)
                    if (slot < 0 && !tw_active[i])
                        slot = i;
                if (slot < 0)
                    return;
                tw_node[slot] = it.node_id;
                tw_prop[slot] = it.property_req;
                tw_dest[slot] = it.color_dest;
                tw_start[slot] = it.start_value;
                tw_end[slot] = it.end_value;
                tw_dur[slot] = it.frames;
                tw_frame[slot] = 0;
                tw_active[slot] = 1;
            end
            CMD_CANCEL:
            begin
                if (it.node_id == 0)
                    return;
                for (int i = 0; i < NSLOT; i++)
                    if (tw_active[i] && tw_node[i] == it.node_id)
                        tw_active[i] = 0;
            end
            CMD_TICK:
            begin
                for (int i = 0; i < NSLOT; i++)
                begin
                    if (!tw_active[i])
                        continue;
                    tw_frame[i] = tw_frame[i] + 1;
                    r = '0;
                    r.out_node = tw_node[i];
                    r.out_property = tw_prop[i];
                    r.out_color_dest = tw_dest[i];
                    r.value = (tw_prop[i] == PROP_COLOUR)
                        ? lerp_argb(tw_start[i], tw_end[i], tw_frame[i], tw_dur[i])
                        : lerp_word(tw_start[i], tw_end[i], tw_frame[i], tw_dur[i]);
                    r.finished = tw_frame[i] >= tw_dur[i];
                    if (r.finished)
                        tw_active[i] = 0;
                    else
                        run = 1;
                    pending_results.push_back(r);
                end
                r = '0;
                r.kind = 1'b1;
                r.running = run;
                r.last = 1'b1;
                pending_results.push_back(r);
            end
            default: ;
        endcase
    endtask

    // result checker
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item %p", out_ch.data);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_ch.data !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p actual %p", want, out_ch.data);
                end
            end
        end
    end

    // receiver with random stalls
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready <= !hold_rx && (quiet || $urandom_range(99) >= 6);
        end
    end

    // watchdog: cycles with nothing accepted
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else if (rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("animation_tween_table test failed");
            $finish;
        end
    end

    // valid stays high between back-to-back calls unless a random idle drops it; callers drop it before a pause
    task automatic send_item(in_item_t it);
        while (!quiet && $urandom_range(99) < 6)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_tween(it);
        @(negedge clk);
    endtask

    function automatic in_item_t make_item(logic [1:0] c, logic [15:0] n, logic [2:0] p,
                                           logic [31:0] d, logic [31:0] s, logic [31:0] e,
                                           logic [15:0] f);
        in_item_t it;
        it.cmd = c;
        it.node_id = n;
        it.property_req = p;
        it.color_dest = d;
        it.start_value = s;
        it.end_value = e;
        it.frames = f;
        return it;
    endfunction

    function automatic in_item_t rand_item();
        in_item_t it;
        int k;
        k = $urandom_range(99);
        it = make_item(CMD_START, 16'($urandom_range(1, 6)), 3'($urandom_range(7)),
                       $urandom, $urandom, $urandom, 16'($urandom_range(1, 4)));
        if (k < 3)
            it.node_id = 16'($urandom);
        else if (k < 5)
            it.frames = 16'($urandom);
        else if (k < 7)
            it.frames = 0;
        else if (k < 9)
            it.cmd = CMD_NONE;
        else if (k < 16)
            it.cmd = CMD_CANCEL;
        else if (k < 55)
            it.cmd = CMD_TICK;
        if ($urandom_range(9) == 0)
            it.node_id = 0;
        return it;
    endfunction

    in_item_t directed [$];

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        for (int i = 0; i < NSLOT; i++)
            tw_active[i] = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // tick on empty table, ignored starts, extremes, colour, reuse, cancel
        directed = '{
            make_item(CMD_TICK, 0, 0, 0, 0, 0, 0),
            make_item(CMD_START, 0, 0, 0, 1, 2, 5),
            make_item(CMD_START, 7, 0, 0, 1, 2, 0),
            make_item(CMD_CANCEL, 0, 0, 0, 0, 0, 0),
            make_item(CMD_NONE, 16'hFFFF, 7, '1, '1, '1, '1),
            make_item(CMD_START, 16'hFFFF, 0, '1, 32'h8000_0000, 32'h7FFF_FFFF, 3),
            make_item(CMD_START, 1, 1, 0, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF),
            make_item(CMD_START, 2, PROP_COLOUR, 32'hDEAD_BEEF, 32'hFF00_80FF,
                      32'h00FF_7F00, 2),
            make_item(CMD_START, 3, 7, 0, 100, -100, 1),
            make_item(CMD_START, 3, 6, 0, 0, 10, 4),
            make_item(CMD_TICK, 0, 0, 0, 0, 0, 0),
            make_item(CMD_START, 3, 6, 5, 10, 0, 2),
            make_item(CMD_TICK, 0, 0, 0, 0, 0, 0),
            make_item(CMD_CANCEL, 1, 0, 0, 0, 0, 0),
            make_item(CMD_TICK, 0, 0, 0, 0, 0, 0),
            make_item(CMD_TICK, 0, 0, 0, 0, 0, 0)
        };
        foreach (directed[i])
            send_item(directed[i]);

        // fill the table past full
        for (int i = 0; i < NSLOT + 2; i++)
            send_item(make_item(CMD_START, 16'(10 + i), PROP_COLOUR, $urandom, $urandom,
                                $urandom, 2));
        send_item(make_item(CMD_TICK, 0, 0, 0, 0, 0, 0));

        // receiver holds off while items keep coming
        fork
            begin
                hold_rx = 1'b1;
                repeat (20000) @(posedge clk);
                hold_rx = 1'b0;
            end
            for (int i = 0; i < 6; i++)
                send_item(make_item(CMD_TICK, 0, 0, 0, 0, 0, 0));
        join
        in_ch.valid <= 1'b0;

        // sender pause until drained
        while (pending_results.size() != 0)
            @(negedge clk);

        for (int i = 0; i < 130; i++)
        begin
            quiet = (i >= 60 && i < 100);
            send_item(rand_item());
        end
        quiet = 1'b0;
        in_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4000) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("animation_tween_table test passed");
        else
            $display("animation_tween_table test failed");
        $finish;
    end
endmodule

// ===== files.f =====
sv/att_pkg.sv
sv/att_in_if.sv
sv/att_out_if.sv
sv/att_front.sv
sv/att_divider.sv
sv/att_back.sv
sv/animation_tween_table.sv
tb/sv/animation_tween_table_tb.sv
